[rtl/fosm_pkg.sv]
// ----------------------------------------------------------------------------
// fosm_pkg: shared types and constants
// Field widths, request codes and the structs passed between the modules of
// the first-occurrence sequence matcher.
// ----------------------------------------------------------------------------
package fosm_pkg;

  // Fixed field widths.
  localparam int CFG_W  = 5;   // pattern_length register
  localparam int SLOT_W = 4;   // pattern_slot field
  localparam int POS_W  = 16;  // match_position field

  // Request type codes.
  localparam logic REQ_LOAD = 1'b0;
  localparam logic REQ_TEXT = 1'b1;

  // Control broadcast from the top level to every cell.
  typedef struct packed {
    logic step;  // text word takes part in matching this cycle
    logic clr;   // search ends this cycle, partial match bits drop
  } cell_ctrl_t;

  // One search result.
  typedef struct packed {
    logic             found;
    logic [POS_W-1:0] match_position;
  } result_t;

endpackage

[rtl/fosm_ifs.sv]
// ----------------------------------------------------------------------------
// fosm request and response channels
// Valid/ready channels carrying request words into the matcher and result
// words out of it.
// ----------------------------------------------------------------------------
interface fosm_req_if #(
  parameter int ELEM_WIDTH = 32
) ();
  logic                       valid;
  logic                       ready;
  logic                       req_type;
  logic [fosm_pkg::SLOT_W-1:0] pattern_slot;
  logic [ELEM_WIDTH-1:0]      element;
  logic                       text_last;

  modport source (output valid, req_type, pattern_slot, element, text_last,
                  input ready);
  modport sink   (input valid, req_type, pattern_slot, element, text_last,
                  output ready);
endinterface

interface fosm_rsp_if ();
  logic                       valid;
  logic                       ready;
  logic                       found;
  logic [fosm_pkg::POS_W-1:0] match_position;

  modport source (output valid, found, match_position, input ready);
  modport sink   (input valid, found, match_position, output ready);
endinterface

[rtl/fosm_cell.sv]
// ----------------------------------------------------------------------------
// fosm_cell: one position of the shift-and chain
// Holds one pattern word and the partial match bit for the prefix that ends
// at this position; takes the bit of its left neighbor every in-range text word.
// ----------------------------------------------------------------------------
module fosm_cell #(
  parameter int ELEM_WIDTH = 32,
  parameter int LW         = 5,
  parameter int IDX        = 0
) (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 load_en,
  input  logic [ELEM_WIDTH-1:0] load_data,
  input  fosm_pkg::cell_ctrl_t ctrl,
  input  logic [ELEM_WIDTH-1:0] text_word,
  input  logic [LW-1:0]        len,
  input  logic                 prev_bit,
  output logic                 match_bit,
  output logic                 hit
);

  logic [ELEM_WIDTH-1:0] pat_word;
  logic                  active;
  logic                  tail;
  logic                  new_bit;

  assign active  = LW'(IDX) < len;
  assign tail    = LW'(IDX + 1) == len;
  assign new_bit = prev_bit && active && (pat_word == text_word);
  assign hit     = ctrl.step && new_bit && tail;

  always_ff @(posedge clk) begin
    if (load_en) begin
      pat_word <= load_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      match_bit <= 1'b0;
    end else if (ctrl.clr) begin
      match_bit <= 1'b0;
    end else if (ctrl.step) begin
      match_bit <= new_bit;
    end
  end

endmodule

[rtl/fosm_out_buf.sv]
// ----------------------------------------------------------------------------
// fosm_out_buf: result output register with skid stage
// Two-entry buffer so the matcher keeps taking words while a result waits.
// ----------------------------------------------------------------------------
module fosm_out_buf (
  input  logic              clk,
  input  logic              rst,
  input  logic              push,
  input  fosm_pkg::result_t push_data,
  output logic              full,
  fosm_rsp_if.source        rsp
);

  logic              out_valid;
  fosm_pkg::result_t out_data;
  logic              skid_valid;
  fosm_pkg::result_t skid_data;
  logic              hold;

  assign hold               = out_valid && !rsp.ready;
  assign full               = skid_valid;
  assign rsp.valid          = out_valid;
  assign rsp.found          = out_data.found;
  assign rsp.match_position = out_data.match_position;

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid  <= 1'b0;
      skid_valid <= 1'b0;
    end else if (hold) begin
      if (push) begin
        skid_valid <= 1'b1;
      end
    end else begin
      out_valid  <= skid_valid || push;
      skid_valid <= skid_valid && push;
    end
  end

  always_ff @(posedge clk) begin
    if (hold) begin
      if (push) begin
        skid_data <= push_data;
      end
    end else begin
      if (skid_valid) begin
        out_data <= skid_data;
        if (push) begin
          skid_data <= push_data;
        end
      end else if (push) begin
        out_data <= push_data;
      end
    end
  end

endmodule

[rtl/first_occurrence_sequence_match.sv]
// ----------------------------------------------------------------------------
// first_occurrence_sequence_match: streaming first-occurrence pattern search
// Shift-and search over a chain of cells, one cell per pattern word.
// ----------------------------------------------------------------------------
// Throughput: one request word per cycle while the output buffer's skid stage
//   is free, pattern loads and text words alike; the shift-and chain updates
//   every cell in the cycle an in-range text word arrives. The last text
//   word's result waits in the two-entry output buffer while input continues.
// Reset (rst, synchronous): clears the search state, pattern_length and the
//   output buffer; the pattern store keeps whatever it held (undefined).
// ----------------------------------------------------------------------------
module first_occurrence_sequence_match #(
  parameter int MAX_PATTERN = 16,
  parameter int MAX_TEXT    = 65536,
  parameter int ELEM_WIDTH  = 32
) (
  input  logic                       clk,
  input  logic                       rst,
  input  logic                       cfg_wr_en,
  input  logic [fosm_pkg::CFG_W-1:0] cfg_wr_data,
  fosm_req_if.sink                   req,
  fosm_rsp_if.source                 rsp
);

  // Width of the effective pattern length, of the text index (which must
  // hold MAX_TEXT itself as its saturated value), and of the start math.
  localparam int LW = $clog2(MAX_PATTERN + 1);
  localparam int TW = $clog2(MAX_TEXT + 1);
  localparam int CW = TW + fosm_pkg::POS_W;

  // Configuration register.
  logic [fosm_pkg::CFG_W-1:0] pattern_length;
  logic [LW-1:0]              len_eff;

  // Search state.
  logic [TW-1:0]               text_index;
  logic                        hit_seen;
  logic [fosm_pkg::POS_W-1:0]  first_hit_start;

  // Request decode.
  logic                 accept;
  logic                 is_text;
  logic                 text_acc;
  logic                 in_range;
  logic                 last;
  fosm_pkg::cell_ctrl_t ctrl;

  // Chain outputs.
  logic [MAX_PATTERN-1:0] pm_bits;
  logic [MAX_PATTERN-1:0] hit_bits;
  logic                   hit_any;
  logic [CW-1:0]          start_c;
  logic                   start_ok;
  logic                   new_hit;

  // Result path.
  fosm_pkg::result_t result;
  logic              buf_full;

  always_ff @(posedge clk) begin
    if (rst) begin
      pattern_length <= '0;
    end else if (cfg_wr_en) begin
      pattern_length <= cfg_wr_data;
    end
  end

  // A length beyond the number of cells is taken as the full chain.
  assign len_eff = (int'(pattern_length) > MAX_PATTERN) ? LW'(MAX_PATTERN)
                                                        : LW'(pattern_length);

  // The buffer can always take a result unless its skid stage is occupied.
  assign req.ready = !buf_full;
  assign accept    = req.valid && req.ready;
  assign is_text   = req.req_type == fosm_pkg::REQ_TEXT;
  assign text_acc  = accept && is_text;

  // Text words past the index limit are neither counted nor matched.
  assign in_range  = text_index != TW'(MAX_TEXT);
  assign last      = text_acc && req.text_last;
  assign ctrl.step = text_acc && in_range;
  assign ctrl.clr  = last;

  // Cell k holds pattern word k. Its partial match bit says that the prefix
  // of length k+1 ends at the latest text word; it is fed by the bit of cell
  // k-1 from the previous word, and cell 0 is always fed a one.
  for (genvar k = 0; k < MAX_PATTERN; k++) begin : g_cell
    logic prev_bit;
    logic load_en;

    if (k == 0) begin : g_head
      assign prev_bit = 1'b1;
    end else begin : g_link
      assign prev_bit = pm_bits[k-1];
    end

    // A slot past the last cell matches no cell and is dropped.
    assign load_en = accept && !is_text && (int'(req.pattern_slot) == k);

    fosm_cell #(
      .ELEM_WIDTH (ELEM_WIDTH),
      .LW         (LW),
      .IDX        (k)
    ) u_cell (
      .clk       (clk),
      .rst       (rst),
      .load_en   (load_en),
      .load_data (req.element),
      .ctrl      (ctrl),
      .text_word (req.element),
      .len       (len_eff),
      .prev_bit  (prev_bit),
      .match_bit (pm_bits[k]),
      .hit       (hit_bits[k])
    );
  end

  // Only the cell at the pattern's last position can raise a hit, so the OR
  // picks it out. A full match needs at least len words, so the start below
  // never wraps.
  assign hit_any  = |hit_bits;
  assign start_c  = CW'(text_index) + CW'(1) - CW'(len_eff);
  assign start_ok = (start_c >> fosm_pkg::POS_W) == '0;
  assign new_hit  = hit_any && !hit_seen && start_ok;

  always_ff @(posedge clk) begin
    if (rst) begin
      text_index      <= '0;
      hit_seen        <= 1'b0;
      first_hit_start <= '0;
    end else if (last) begin
      text_index      <= '0;
      hit_seen        <= 1'b0;
      first_hit_start <= '0;
    end else if (ctrl.step) begin
      text_index <= text_index + TW'(1);
      if (new_hit) begin
        hit_seen        <= 1'b1;
        first_hit_start <= start_c[fosm_pkg::POS_W-1:0];
      end
    end
  end

  // The last word may itself complete the first match.
  always_comb begin
    result.found = hit_seen || new_hit;
    if (hit_seen) begin
      result.match_position = first_hit_start;
    end else if (new_hit) begin
      result.match_position = start_c[fosm_pkg::POS_W-1:0];
    end else begin
      result.match_position = '0;
    end
  end

  fosm_out_buf u_out_buf (
    .clk       (clk),
    .rst       (rst),
    .push      (last),
    .push_data (result),
    .full      (buf_full),
    .rsp       (rsp)
  );

  // A result reports position zero whenever it reports no match.
  a_pos_zero_when_missed: assert property (
    @(posedge clk) disable iff (rst)
    rsp.valid && !rsp.found |-> rsp.match_position == '0
  ) else $error("match_position nonzero on a not-found result");

  // The skid stage only fills behind a waiting output register.
  a_skid_behind_out: assert property (
    @(posedge clk) disable iff (rst)
    buf_full |-> rsp.valid
  ) else $error("skid stage occupied with output register empty");

  // The last text word of a search leaves a fresh search behind it.
  a_search_cleared: assert property (
    @(posedge clk) disable iff (rst)
    last |=> !hit_seen && text_index == '0 && pm_bits == '0
  ) else $error("search state not cleared after last text word");

  // After a last text word, a result is valid at the output in the next cycle.
  a_result_follows_last: assert property (
    @(posedge clk) disable iff (rst)
    last |=> rsp.valid
  ) else $error("no result after last text word");

endmodule
